// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the palette fade stepper.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define PFS_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pfs check failed");

// Condition c must hold in the cycle after a.
`define PFS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pfs check failed");

`endif

// ===== rtl/pfs_pkg.sv =====
// Shared types, constants and helper functions for the palette fade stepper.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none

package pfs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int CHAN_W    = 8;
  localparam int IDX_W     = 8;
  localparam int ELAPSED_W = 24;
  localparam int DUR_W     = 16;
  localparam int PROD_W    = CHAN_W + ELAPSED_W;
  localparam int DIGITS    = 8;
  localparam int CNT_W     = $clog2(DIGITS);

  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Input mode codes
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_QUERY   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENTRY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ENTRY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_DURATION = 2'd2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] src_red;
    logic [CHAN_W-1:0] src_green;
    logic [CHAN_W-1:0] src_blue;
    logic [CHAN_W-1:0] dst_red;
    logic [CHAN_W-1:0] dst_green;
    logic [CHAN_W-1:0] dst_blue;
  } palette_entry_t;

  function automatic logic [CHAN_W-1:0] gap_of(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Returns {moved, channel value}.
  function automatic logic [CHAN_W:0] fade_channel(input logic [CHAN_W-1:0] s,
                                                   input logic [CHAN_W-1:0] d,
                                                   input logic [CHAN_W-1:0] step);
    logic [CHAN_W:0] res;
    if (gap_of(s, d) > step) begin
      res = {1'b1, (d > s) ? s + step : s - step};
    end else begin
      res = {1'b0, d};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/palette_fade_stepper_top.sv =====
// Palette fade engine. Loads store an entry's source and destination color and, inside
// the range [first_entry, end_entry), widen the largest channel difference; restart clears
// it. A query in range returns the entry's color at elapsed_ticks, with the step
// floor(max_difference * elapsed_ticks / fade_duration) saturated at 255. A query occupies
// the block through a bit-serial multiply, one overflow compare and a restoring divide, one
// quotient bit per cycle; a query whose step saturates skips the divide. Loads, restarts
// and the unused mode go straight to the finish state, which waits while the output is
// stalled. A finished result waits in the output register while the next item is taken.
// Depends on pfs_pkg, pfs_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module palette_fade_stepper_top #(
  parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [pfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [1:0]                          mode,
  input  wire logic [pfs_pkg::IDX_W-1:0]           entry_index,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          src_red,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          src_green,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          src_blue,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          dst_red,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          dst_green,
  input  wire logic [pfs_pkg::CHAN_W-1:0]          dst_blue,
  input  wire logic [pfs_pkg::ELAPSED_W-1:0]       elapsed_ticks,
  input  wire logic                                sweep_end,
  // output channel
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [pfs_pkg::CHAN_W-1:0]          out_red,
  output      logic [pfs_pkg::CHAN_W-1:0]          out_green,
  output      logic [pfs_pkg::CHAN_W-1:0]          out_blue,
  output      logic                                entry_moving,
  output      logic                                fade_finished,
  output      logic                                in_range
);

  localparam int AW   = $clog2(PALETTE_ENTRIES);
  localparam int IDXW = (AW > pfs_pkg::IDX_W) ? AW : pfs_pkg::IDX_W;
  localparam int CW   = pfs_pkg::CHAN_W;
  localparam int DW   = pfs_pkg::DUR_W;
  localparam int PW   = pfs_pkg::PROD_W;
  localparam int NDIG = pfs_pkg::DIGITS;
  localparam logic [pfs_pkg::CNT_W-1:0] CNT_LAST = pfs_pkg::CNT_W'(NDIG - 1);

  // configuration registers
  logic [7:0]    first_entry;
  logic [8:0]    end_entry;
  logic [DW-1:0] fade_duration;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_entry   <= '0;
      end_entry     <= 9'd256;
      fade_duration <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfs_pkg::CFG_FIRST_ENTRY:   first_entry   <= cfg_data[7:0];
        pfs_pkg::CFG_END_ENTRY:     end_entry     <= cfg_data[8:0];
        pfs_pkg::CFG_FADE_DURATION: fade_duration <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  pfs_pkg::state_t state, state_next;
  logic               in_acc;
  logic [IDXW-1:0]    idx_wide;
  logic [AW-1:0]      addr;
  logic               idx_ok;
  logic               idx_in_range;
  logic [DW-1:0]      dur_eff;

  assign in_stall     = (state != pfs_pkg::S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign idx_wide     = IDXW'(entry_index);
  assign addr         = idx_wide[AW-1:0];
  assign idx_ok       = (32'(entry_index) < 32'(PALETTE_ENTRIES));
  assign idx_in_range = idx_ok && (entry_index >= first_entry)
                        && ({1'b0, entry_index} < end_entry);
  assign dur_eff      = (fade_duration == '0) ? DW'(1) : fade_duration;

  // palette store
  pfs_pkg::palette_entry_t wr_entry, rd_entry;
  logic [$bits(pfs_pkg::palette_entry_t)-1:0] rd_bits;
  logic ram_we, ram_re;

  assign wr_entry = '{src_red: src_red, src_green: src_green, src_blue: src_blue,
                      dst_red: dst_red, dst_green: dst_green, dst_blue: dst_blue};
  assign ram_we   = in_acc && (mode == pfs_pkg::MODE_LOAD) && idx_ok;
  assign ram_re   = in_acc && (mode == pfs_pkg::MODE_QUERY);
  assign rd_entry = pfs_pkg::palette_entry_t'(rd_bits);

  pfs_ram #(
    .WIDTH ($bits(pfs_pkg::palette_entry_t)),
    .DEPTH (PALETTE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr),
    .wr_data (wr_entry),
    .rd_en   (ram_re),
    .rd_addr (addr),
    .rd_data (rd_bits)
  );

  // largest channel difference of the entry being loaded
  logic [CW-1:0] gap_r, gap_g, gap_b, gap_max;
  assign gap_r   = pfs_pkg::gap_of(src_red, dst_red);
  assign gap_g   = pfs_pkg::gap_of(src_green, dst_green);
  assign gap_b   = pfs_pkg::gap_of(src_blue, dst_blue);
  assign gap_max = (gap_r > gap_g) ? ((gap_r > gap_b) ? gap_r : gap_b)
                                   : ((gap_g > gap_b) ? gap_g : gap_b);

  // datapath registers
  logic [1:0]                  mode_q;
  logic                        idx_ok_q, in_range_q, last_q;
  logic [pfs_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [DW-1:0]               dur_q;
  logic [CW-1:0]               mult_sr;
  logic [PW-1:0]               acc;
  logic [DW-1:0]               rem;
  logic [CW-1:0]               low_sr;
  logic [CW-1:0]               quot;
  logic                        sat;
  logic [pfs_pkg::CNT_W-1:0]   cnt;
  logic [CW-1:0]               max_difference;
  logic                        sweep_moved;

  // one restoring divide step
  logic [DW:0] trial, trial_diff;
  logic        trial_ge;
  assign trial      = {rem, low_sr[CW-1]};
  assign trial_ge   = (trial >= {1'b0, dur_q});
  assign trial_diff = trial - {1'b0, dur_q};

  // result assembly
  logic [CW-1:0] step;
  logic [CW:0]   fr, fg, fb;
  logic          moving, is_query, out_load;
  logic [CW-1:0] res_red, res_green, res_blue;

  assign step     = sat ? pfs_pkg::CHAN_MAX : quot;
  assign fr       = pfs_pkg::fade_channel(rd_entry.src_red, rd_entry.dst_red, step);
  assign fg       = pfs_pkg::fade_channel(rd_entry.src_green, rd_entry.dst_green, step);
  assign fb       = pfs_pkg::fade_channel(rd_entry.src_blue, rd_entry.dst_blue, step);
  assign is_query = (mode_q == pfs_pkg::MODE_QUERY);
  assign moving   = is_query && in_range_q && (fr[CW] || fg[CW] || fb[CW]);
  assign out_load = (state == pfs_pkg::S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    res_red   = '0;
    res_green = '0;
    res_blue  = '0;
    if (is_query && in_range_q) begin
      res_red   = fr[CW-1:0];
      res_green = fg[CW-1:0];
      res_blue  = fb[CW-1:0];
    end else if (is_query && idx_ok_q) begin
      res_red   = rd_entry.dst_red;
      res_green = rd_entry.dst_green;
      res_blue  = rd_entry.dst_blue;
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pfs_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = (mode == pfs_pkg::MODE_QUERY) ? pfs_pkg::S_MUL : pfs_pkg::S_FINISH;
        end
      end
      pfs_pkg::S_MUL: begin
        if (cnt == CNT_LAST) state_next = pfs_pkg::S_CMP;
      end
      pfs_pkg::S_CMP: begin
        state_next = (acc[PW-1:NDIG] >= (PW-NDIG)'(dur_q)) ? pfs_pkg::S_FINISH
                                                             : pfs_pkg::S_DIV;
      end
      pfs_pkg::S_DIV: begin
        if (cnt == CNT_LAST) state_next = pfs_pkg::S_FINISH;
      end
      pfs_pkg::S_FINISH: begin
        if (out_load) state_next = pfs_pkg::S_IDLE;
      end
      default: state_next = pfs_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      max_difference <= '0;
      sweep_moved    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == pfs_pkg::S_MUL || state == pfs_pkg::S_DIV) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
      end
      if (in_acc && mode == pfs_pkg::MODE_LOAD && idx_in_range
          && gap_max > max_difference) begin
        max_difference <= gap_max;
      end else if (in_acc && mode == pfs_pkg::MODE_RESTART) begin
        max_difference <= '0;
      end
      if (in_acc && mode == pfs_pkg::MODE_RESTART) begin
        sweep_moved <= 1'b0;
      end else if (out_load && is_query) begin
        // a sweep end drops the flag after reporting it
        sweep_moved <= last_q ? 1'b0 : (sweep_moved || moving);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q     <= mode;
      idx_ok_q   <= idx_ok;
      in_range_q <= idx_in_range;
      last_q     <= sweep_end;
      elapsed_q  <= elapsed_ticks;
      dur_q      <= dur_eff;
      mult_sr    <= max_difference;
      acc        <= '0;
      sat        <= 1'b0;
      quot       <= '0;
    end
    unique case (state)
      pfs_pkg::S_MUL: begin
        // multiplier bits enter MSB first
        acc     <= {acc[PW-2:0], 1'b0} + (mult_sr[CW-1] ? PW'(elapsed_q) : '0);
        mult_sr <= {mult_sr[CW-2:0], 1'b0};
      end
      pfs_pkg::S_CMP: begin
        sat    <= (acc[PW-1:NDIG] >= (PW-NDIG)'(dur_q));
        rem    <= acc[NDIG+DW-1:NDIG];
        low_sr <= acc[NDIG-1:0];
      end
      pfs_pkg::S_DIV: begin
        rem    <= trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
        quot   <= {quot[CW-2:0], trial_ge};
        low_sr <= {low_sr[CW-2:0], 1'b0};
      end
      default: ;
    endcase
    if (out_load) begin
      out_red       <= res_red;
      out_green     <= res_green;
      out_blue      <= res_blue;
      entry_moving  <= moving;
      fade_finished <= is_query && last_q && !(sweep_moved || moving);
      in_range      <= is_query && in_range_q;
    end
  end

  // checks
  `PFS_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_acc, in_stall)
  `PFS_ASSERT_SAME(a_rem_below_divisor, clk, rst, state == pfs_pkg::S_DIV, rem < dur_q)
  `PFS_ASSERT_SAME(a_moving_in_range, clk, rst, out_valid && entry_moving, in_range)
  `PFS_ASSERT_SAME(a_moving_not_finished, clk, rst, out_valid && entry_moving, !fade_finished)

endmodule

`default_nettype wire

// ===== rtl/pfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pfs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/palette_fade_checker.sv =====
// Checker for the palette fade stepper: watches the configuration port and both channels,
// predicts every result from its own copy of the palette and fade state, and compares.
// Depends on pfs_pkg for field widths, mode codes and register indexes.
module palette_fade_checker #(
  parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [pfs_pkg::IDX_W-1:0]      entry_index,
  input  logic [pfs_pkg::CHAN_W-1:0]     src_red,
  input  logic [pfs_pkg::CHAN_W-1:0]     src_green,
  input  logic [pfs_pkg::CHAN_W-1:0]     src_blue,
  input  logic [pfs_pkg::CHAN_W-1:0]     dst_red,
  input  logic [pfs_pkg::CHAN_W-1:0]     dst_green,
  input  logic [pfs_pkg::CHAN_W-1:0]     dst_blue,
  input  logic [pfs_pkg::ELAPSED_W-1:0]  elapsed_ticks,
  input  logic                           sweep_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [pfs_pkg::CHAN_W-1:0]     out_red,
  input  logic [pfs_pkg::CHAN_W-1:0]     out_green,
  input  logic [pfs_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           entry_moving,
  input  logic                           fade_finished,
  input  logic                           in_range,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = pfs_pkg::CHAN_W;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          moving;
    logic          finished;
    logic          ranged;
  } faded_colour_t;

  pfs_pkg::palette_entry_t  colours [PALETTE_ENTRIES];
  logic [CW-1:0]            peak_gap;
  logic                     swept_motion;
  logic [7:0]               win_first;
  logic [8:0]               win_end;
  logic [pfs_pkg::DUR_W-1:0] duration;
  faded_colour_t            awaited [$];

  function automatic logic [CW-1:0] chan_gap(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [CW-1:0] chan_toward(input logic [CW-1:0] s,
                                                input logic [CW-1:0] d,
                                                input logic [CW-1:0] step,
                                                output logic moved);
    moved = chan_gap(s, d) > step;
    if (moved) begin
      return (d > s) ? s + step : s - step;
    end
    return d;
  endfunction

  function automatic logic in_window(input logic [pfs_pkg::IDX_W-1:0] idx);
    return int'(idx) >= int'(win_first) && int'(idx) < int'(win_end) &&
           int'(idx) < PALETTE_ENTRIES;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    faded_colour_t           want;
    pfs_pkg::palette_entry_t ent;
    logic [31:0]             prod;
    logic [31:0]             quot;
    logic [31:0]             divisor;
    logic [CW-1:0]           step;
    logic                    mv_r;
    logic                    mv_g;
    logic                    mv_b;
    logic                    moving;
    if (rst) begin
      peak_gap     = '0;
      swept_motion = 1'b0;
      win_first    = 8'd0;
      win_end      = 9'd256;
      duration     = 16'd1000;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfs_pkg::CFG_FIRST_ENTRY:   win_first = cfg_data[7:0];
          pfs_pkg::CFG_END_ENTRY:     win_end   = cfg_data[8:0];
          pfs_pkg::CFG_FADE_DURATION: duration  = cfg_data[pfs_pkg::DUR_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errors++;
        end else begin
          want = awaited.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("entry_moving", want.moving, entry_moving);
          check_field("fade_finished", want.finished, fade_finished);
          check_field("in_range", want.ranged, in_range);
        end
      end

      if (in_valid && !in_stall) begin
        want = '0;
        case (mode)
          pfs_pkg::MODE_LOAD: begin
            if (int'(entry_index) < PALETTE_ENTRIES) begin
              ent = '{src_red, src_green, src_blue, dst_red, dst_green, dst_blue};
              colours[entry_index] = ent;
              if (in_window(entry_index)) begin
                if (chan_gap(ent.src_red, ent.dst_red) > peak_gap)
                  peak_gap = chan_gap(ent.src_red, ent.dst_red);
                if (chan_gap(ent.src_green, ent.dst_green) > peak_gap)
                  peak_gap = chan_gap(ent.src_green, ent.dst_green);
                if (chan_gap(ent.src_blue, ent.dst_blue) > peak_gap)
                  peak_gap = chan_gap(ent.src_blue, ent.dst_blue);
              end
            end
          end
          pfs_pkg::MODE_RESTART: begin
            peak_gap     = '0;
            swept_motion = 1'b0;
          end
          pfs_pkg::MODE_QUERY: begin
            moving = 1'b0;
            if (int'(entry_index) < PALETTE_ENTRIES) begin
              ent = colours[entry_index];
              if (in_window(entry_index)) begin
                // zero duration behaves as one tick
                divisor = (duration == '0) ? 32'd1 : 32'(duration);
                prod    = 32'(peak_gap) * 32'(elapsed_ticks);
                quot    = prod / divisor;
                step    = (quot > 32'(pfs_pkg::CHAN_MAX)) ? pfs_pkg::CHAN_MAX
                                                          : quot[CW-1:0];
                want.red    = chan_toward(ent.src_red, ent.dst_red, step, mv_r);
                want.green  = chan_toward(ent.src_green, ent.dst_green, step, mv_g);
                want.blue   = chan_toward(ent.src_blue, ent.dst_blue, step, mv_b);
                moving      = mv_r | mv_g | mv_b;
                want.ranged = 1'b1;
              end else begin
                want.red   = ent.dst_red;
                want.green = ent.dst_green;
                want.blue  = ent.dst_blue;
              end
            end
            if (moving) swept_motion = 1'b1;
            want.moving = moving;
            if (sweep_end) begin
              want.finished = !swept_motion;
              swept_motion  = 1'b0;
            end
          end
          default: ;
        endcase
        awaited.push_back(want);
      end
    end
    pending <= awaited.size();
  end

endmodule

// ===== tb/palette_fade_stepper_top_tb.sv =====
// Stimulus and verdict for the palette fade stepper: directed corner cases, then fade
// sweeps under changing windows and durations, with random idling on both channels.
// Depends on pfs_pkg, palette_fade_stepper_top and palette_fade_checker.
module palette_fade_stepper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int ITEM_TARGET    = 1700;
  localparam int CALM_AFTER     = 1500;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     mode = '0;
  logic [pfs_pkg::IDX_W-1:0]      entry_index = '0;
  logic [pfs_pkg::CHAN_W-1:0]     src_red = '0;
  logic [pfs_pkg::CHAN_W-1:0]     src_green = '0;
  logic [pfs_pkg::CHAN_W-1:0]     src_blue = '0;
  logic [pfs_pkg::CHAN_W-1:0]     dst_red = '0;
  logic [pfs_pkg::CHAN_W-1:0]     dst_green = '0;
  logic [pfs_pkg::CHAN_W-1:0]     dst_blue = '0;
  logic [pfs_pkg::ELAPSED_W-1:0]  elapsed_ticks = '0;
  logic                           sweep_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [pfs_pkg::CHAN_W-1:0]     out_red;
  logic [pfs_pkg::CHAN_W-1:0]     out_green;
  logic [pfs_pkg::CHAN_W-1:0]     out_blue;
  logic                           entry_moving;
  logic                           fade_finished;
  logic                           in_range;

  int errors;
  int pending;

  int sent         = 0;
  int quiet_cycles = 0;
  int stall_run    = 0;
  int in_gap_pct   = 0;
  int out_gap_pct  = 0;
  bit calm         = 1'b0;

  bit         loaded [256];
  logic [7:0] loaded_list [$];
  int         win_lo  = 0;
  int         win_hi  = 256;
  int         win_dur = 1000;

  palette_fade_stepper_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .entry_index(entry_index),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue),
    .dst_red(dst_red), .dst_green(dst_green), .dst_blue(dst_blue),
    .elapsed_ticks(elapsed_ticks), .sweep_end(sweep_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .entry_moving(entry_moving), .fade_finished(fade_finished), .in_range(in_range)
  );

  palette_fade_checker fade_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .entry_index(entry_index),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue),
    .dst_red(dst_red), .dst_green(dst_green), .dst_blue(dst_blue),
    .elapsed_ticks(elapsed_ticks), .sweep_end(sweep_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .entry_moving(entry_moving), .fade_finished(fade_finished), .in_range(in_range),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // receiver holds off in random bursts
  always @(posedge clk) begin
    if (stall_run > 0) stall_run = stall_run - 1;
    else if (!calm && $urandom_range(0, 99) < out_gap_pct) stall_run = $urandom_range(1, 6);
    out_stall <= (stall_run > 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [47:0] rand_colour();
    logic [47:0] c;
    c[31:0]  = $urandom();
    c[47:32] = 16'($urandom());
    return c;
  endfunction

  function automatic logic [7:0] any_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Present one item and hold it until the transfer; valid stays high unless a gap follows.
  task automatic send_item(input logic [1:0] m, input logic [7:0] idx,
                           input logic [47:0] colour, input logic [23:0] ticks,
                           input logic last);
    mode          <= m;
    entry_index   <= idx;
    {src_red, src_green, src_blue, dst_red, dst_green, dst_blue} <= colour;
    elapsed_ticks <= ticks;
    sweep_end     <= last;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (m == pfs_pkg::MODE_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [47:0] colour);
    send_item(pfs_pkg::MODE_LOAD, idx, colour, 24'($urandom()), 1'($urandom()));
  endtask

  task automatic send_query(input logic [7:0] idx, input logic [23:0] ticks,
                            input logic last);
    send_item(pfs_pkg::MODE_QUERY, idx, rand_colour(), ticks, last);
  endtask

  task automatic send_restart();
    send_item(pfs_pkg::MODE_RESTART, 8'($urandom()), rand_colour(), 24'($urandom()),
              1'($urandom()));
  endtask

  // Drain every prediction, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input int first, input int past_last, input int dur);
    cfg_we    <= 1'b1;
    cfg_index <= pfs_pkg::CFG_FIRST_ENTRY;
    cfg_data  <= pfs_pkg::CFG_DATA_W'(first);
    @(posedge clk);
    cfg_index <= pfs_pkg::CFG_END_ENTRY;
    cfg_data  <= pfs_pkg::CFG_DATA_W'(past_last);
    @(posedge clk);
    cfg_index <= pfs_pkg::CFG_FADE_DURATION;
    cfg_data  <= pfs_pkg::CFG_DATA_W'(dur);
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_lo  = first;
    win_hi  = past_last;
    win_dur = (dur == 0) ? 1 : dur;
  endtask

  initial begin
    int         n_ent;
    int         steps;
    int         ticks;
    logic [7:0] idx;
    logic [47:0] colour;
    logic [7:0] group [$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners on reset settings
    send_restart();
    send_load(8'd0, 48'h000000_FFFFFF);
    send_load(8'd255, 48'hFFFFFF_000000);
    send_load(8'd7, 48'h5AA53C_5AA53C);
    send_load(8'd1, 48'h1080F0_2070F0);
    send_query(8'd0, 24'd0, 1'b0);
    send_query(8'd1, 24'd40, 1'b0);
    send_query(8'd0, 24'd500, 1'b0);
    send_query(8'd255, 24'hFFFFFF, 1'b0);
    send_query(8'd7, 24'd1000, 1'b1);
    send_query(8'd7, 24'd1000, 1'b1);
    send_item(MODE_UNUSED, 8'($urandom()), rand_colour(), 24'($urandom()), 1'b1);
    send_item(pfs_pkg::MODE_LOAD, 8'd9, rand_colour(), 24'hFFFFFF, 1'b1);
    send_restart();
    send_query(8'd0, 24'hFFFFFF, 1'b1);
    settle();

    // narrow window with zero duration
    write_window(8, 16, 0);
    send_load(8'd3, 48'h000000_FFFFFF);
    send_load(8'd10, 48'h404040_44403E);
    send_load(8'd15, 48'h808080_808080);
    send_load(8'd16, rand_colour());
    send_query(8'd3, 24'd5, 1'b0);
    send_query(8'd10, 24'd1, 1'b0);
    send_query(8'd16, 24'd0, 1'b1);
    settle();

    // empty window
    write_window(200, 100, 65535);
    send_query(8'd10, 24'd100, 1'b1);
    settle();

    // last entry only, longest duration
    write_window(255, 256, 65535);
    send_load(8'd255, rand_colour());
    send_query(8'd255, 24'hFFFFFF, 1'b1);

    while (sent < ITEM_TARGET) begin
      settle();
      calm = (sent >= CALM_AFTER);
      case ($urandom_range(0, 5))
        0: begin
          ticks = 0;
          n_ent = 256;
        end
        1: begin
          ticks = 255;
          n_ent = 256;
        end
        2: begin
          ticks = $urandom_range(0, 255);
          n_ent = $urandom_range(0, 256);
        end
        default: begin
          ticks = $urandom_range(0, 200);
          n_ent = ticks + $urandom_range(1, 56);
        end
      endcase
      case ($urandom_range(0, 6))
        0: steps = 1;
        1: steps = 65535;
        2: steps = 0;
        3, 4: steps = $urandom_range(1, 300);
        default: steps = $urandom_range(1, 65535);
      endcase
      write_window(ticks, n_ent, steps);
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_gap_pct = 0;
        1: out_gap_pct = 15;
        default: out_gap_pct = 40;
      endcase

      // one fade: restart, load a group, sweep it until every entry lands
      send_restart();
      group.delete();
      n_ent = $urandom_range(1, 6);
      for (int k = 0; k < n_ent; k++) begin
        if (win_lo < win_hi && $urandom_range(0, 9) < 8)
          idx = 8'($urandom_range(win_lo, win_hi - 1));
        else
          idx = 8'($urandom());
        colour = rand_colour();
        if ($urandom_range(0, 4) == 0) colour[23:0] = colour[47:24];
        send_load(idx, colour);
        group.push_back(idx);
      end
      steps = $urandom_range(1, 5);
      for (int t = 0; t <= steps + 1; t++) begin
        for (int k = 0; k < group.size(); k++) begin
          ticks = (t * win_dur) / steps;
          if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, 24'hFFFFFF);
          send_query(group[k], 24'(ticks), k == group.size() - 1);
          if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 3))
              0: send_item(MODE_UNUSED, 8'($urandom()), rand_colour(), 24'($urandom()),
                           1'($urandom()));
              1: send_load(8'($urandom()), rand_colour());
              2: send_query(any_loaded(), 24'($urandom()), 1'($urandom()));
              default: send_restart();
            endcase
          end
        end
      end
    end

    calm = 1'b1;
    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pfs_pkg.sv
rtl/pfs_ram.sv
rtl/palette_fade_stepper_top.sv
tb/palette_fade_checker.sv
tb/palette_fade_stepper_top_tb.sv
